// ===== rtl/core/csvp_pkg.sv =====
// shared types, codes and constants of the csv field parser
`timescale 1ns / 1ps

package csvp_pkg;

    // default for the column limit of the top level
    localparam int MAX_COLUMNS_DEFAULT = 256;

    // depth of the result queue
    localparam int RES_DEPTH = 4;

    // saturation value of the row counter
    localparam logic [23:0] ROW_MAX = 24'hFF_FFFF;

    // characters with a meaning to the parser
    localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
    localparam logic [7:0] CHAR_COMMA   = 8'h2C;
    localparam logic [7:0] CHAR_QUOTE   = 8'h22;

    // result kinds
    localparam logic [1:0] KIND_CONTENT   = 2'd0;
    localparam logic [1:0] KIND_FIELD_END = 2'd1;
    localparam logic [1:0] KIND_ROW_END   = 2'd2;
    localparam logic [1:0] KIND_ERROR     = 2'd3;

    // error codes
    localparam logic [2:0] ERR_NONE       = 3'd0;
    localparam logic [2:0] ERR_UNTERM     = 3'd1;
    localparam logic [2:0] ERR_AFTER_QUOT = 3'd2;
    localparam logic [2:0] ERR_EMPTY_LINE = 3'd3;
    localparam logic [2:0] ERR_COL_COUNT  = 3'd4;
    localparam logic [2:0] ERR_TOO_MANY   = 3'd5;

    // parser phase
    typedef enum logic [2:0] {
        PH_LINE_START,
        PH_FIELD_START,
        PH_UNQUOTED,
        PH_QUOTED,
        PH_QUOTE_SEEN,
        PH_SKIP
    } phase_t;

    // one result transaction
    typedef struct packed {
        logic [7:0]  out_byte;
        logic [1:0]  kind;
        logic [7:0]  column;
        logic [23:0] row;
        logic [2:0]  err_code;
        logic        last_of_run;
    } result_t;

endpackage

// ===== rtl/core/csv_field_parser_unit.sv =====
// top level of the streaming csv field parser
`timescale 1ns / 1ps

// Streaming CSV parser taking one text byte per transaction on the s_ channel and giving
// content bytes, field ends, row ends and errors on the m_ channel, each tagged with
// column and row. A byte gives zero, one or two results; its results are written into
// the registered result queue when the byte is accepted and reach m_ in order. A new
// byte is accepted every cycle while the four-entry result queue holds at most two
// results; the m_ side delivers one result per cycle while m_ready is high, so a byte
// that gives two results (a field or quote byte ending the stream) has them sent in turn.
// After an error, bytes give no results up to the stream_end byte, after which the parser
// starts afresh with a new header row.
module csv_field_parser_unit
    import csvp_pkg::*;
#(
    parameter int MAX_COLUMNS = MAX_COLUMNS_DEFAULT
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_data_byte,
    input  logic        s_stream_end,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_out_byte,
    output logic [1:0]  m_kind,
    output logic [7:0]  m_column,
    output logic [23:0] m_row,
    output logic [2:0]  m_err_code,
    output logic        m_last_of_run
);

    localparam int COL_W = $clog2(MAX_COLUMNS);
    localparam int EXP_W = $clog2(MAX_COLUMNS + 1);

    phase_t           phase_reg;
    phase_t           phase_next;
    logic [COL_W-1:0] col_reg;
    logic [COL_W-1:0] col_next;
    logic [EXP_W-1:0] exp_cols_reg;
    logic [EXP_W-1:0] exp_cols_next;
    logic             hdr_done_reg;
    logic             hdr_done_next;
    logic [23:0]      row_reg;
    logic [23:0]      row_next;
    result_t          res0;
    result_t          res1;
    logic             res0_valid;
    logic             res1_valid;
    logic             accept;
    logic             room_for_two;
    result_t          head;

    assign s_ready = room_for_two;
    assign accept  = s_valid && s_ready;

    // per-byte parsing logic
    csvp_step #(
        .MAX_COLUMNS (MAX_COLUMNS),
        .COL_W       (COL_W),
        .EXP_W       (EXP_W)
    ) u_step (
        .data_byte     (s_data_byte),
        .stream_end    (s_stream_end),
        .phase         (phase_reg),
        .col           (col_reg),
        .exp_cols      (exp_cols_reg),
        .hdr_done      (hdr_done_reg),
        .row           (row_reg),
        .phase_next    (phase_next),
        .col_next      (col_next),
        .exp_cols_next (exp_cols_next),
        .hdr_done_next (hdr_done_next),
        .row_next      (row_next),
        .res0          (res0),
        .res0_valid    (res0_valid),
        .res1          (res1),
        .res1_valid    (res1_valid)
    );

    // parser state, moves on each accepted transaction
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= PH_LINE_START;
            col_reg      <= '0;
            exp_cols_reg <= '0;
            hdr_done_reg <= 1'b0;
            row_reg      <= '0;
        end else if (accept) begin
            phase_reg    <= phase_next;
            col_reg      <= col_next;
            exp_cols_reg <= exp_cols_next;
            hdr_done_reg <= hdr_done_next;
            row_reg      <= row_next;
        end
    end

    // result queue between parser and output channel
    csvp_result_fifo u_fifo (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .wr_data0     (res0),
        .wr_en0       (accept && res0_valid),
        .wr_data1     (res1),
        .wr_en1       (accept && res1_valid),
        .room_for_two (room_for_two),
        .rd_data      (head),
        .rd_valid     (m_valid),
        .rd_ready     (m_ready)
    );

    assign m_out_byte    = head.out_byte;
    assign m_kind        = head.kind;
    assign m_column      = head.column;
    assign m_row         = head.row;
    assign m_err_code    = head.err_code;
    assign m_last_of_run = head.last_of_run;

endmodule

// ===== rtl/core/csvp_step.sv =====
// next-state and result logic for one byte of csv text
`timescale 1ns / 1ps

module csvp_step
    import csvp_pkg::*;
#(
    parameter int MAX_COLUMNS = MAX_COLUMNS_DEFAULT,
    parameter int COL_W       = $clog2(MAX_COLUMNS),
    parameter int EXP_W       = $clog2(MAX_COLUMNS + 1)
) (
    input  logic [7:0]       data_byte,
    input  logic             stream_end,
    input  phase_t           phase,
    input  logic [COL_W-1:0] col,
    input  logic [EXP_W-1:0] exp_cols,
    input  logic             hdr_done,
    input  logic [23:0]      row,
    output phase_t           phase_next,
    output logic [COL_W-1:0] col_next,
    output logic [EXP_W-1:0] exp_cols_next,
    output logic             hdr_done_next,
    output logic [23:0]      row_next,
    output result_t          res0,
    output logic             res0_valid,
    output result_t          res1,
    output logic             res1_valid
);

    localparam logic [COL_W-1:0] COL_LAST = COL_W'(MAX_COLUMNS - 1);

    function automatic result_t make_res(input logic [7:0] b, input logic [1:0] k,
                                         input logic [COL_W-1:0] c,
                                         input logic [23:0] r, input logic [2:0] e);
        result_t res;
        res.out_byte    = b;
        res.kind        = k;
        res.column      = 8'(c);
        res.row         = r;
        res.err_code    = e;
        res.last_of_run = 1'b0;
        return res;
    endfunction

    logic             is_nl;
    logic             is_comma;
    logic             is_quote;
    phase_t           a_phase;
    logic [COL_W-1:0] a_col;
    logic             a_valid;
    result_t          a_res;
    phase_t           e_phase_in;
    logic [COL_W-1:0] e_col_in;
    logic             do_end;
    phase_t           e_phase;
    logic [COL_W-1:0] e_col;
    logic [EXP_W-1:0] e_exp;
    logic             e_hdr;
    logic [23:0]      e_row;
    logic             e_valid;
    result_t          e_res;
    logic [EXP_W-1:0] e_count;

    assign is_nl    = (data_byte == CHAR_NEWLINE);
    assign is_comma = (data_byte == CHAR_COMMA);
    assign is_quote = (data_byte == CHAR_QUOTE);

    // byte handling for anything but a newline
    always_comb begin
        a_phase = phase;
        a_col   = col;
        a_valid = 1'b0;
        a_res   = make_res(8'd0, KIND_CONTENT, col, row, ERR_NONE);
        if (!is_nl) begin
            unique case (phase)
                PH_LINE_START, PH_FIELD_START, PH_UNQUOTED, PH_QUOTE_SEEN: begin
                    a_valid = 1'b1;
                    if (is_comma) begin
                        if (col == COL_LAST) begin
                            a_res   = make_res(8'd0, KIND_ERROR, col, row, ERR_TOO_MANY);
                            a_phase = PH_SKIP;
                        end else begin
                            a_res   = make_res(8'd0, KIND_FIELD_END, col, row, ERR_NONE);
                            a_col   = col + COL_W'(1);
                            a_phase = PH_FIELD_START;
                        end
                    end else if (phase == PH_UNQUOTED) begin
                        a_res = make_res(data_byte, KIND_CONTENT, col, row, ERR_NONE);
                    end else if (phase == PH_QUOTE_SEEN) begin
                        if (is_quote) begin
                            // doubled quote inside a quoted field
                            a_res   = make_res(data_byte, KIND_CONTENT, col, row, ERR_NONE);
                            a_phase = PH_QUOTED;
                        end else begin
                            a_res   = make_res(8'd0, KIND_ERROR, col, row, ERR_AFTER_QUOT);
                            a_phase = PH_SKIP;
                        end
                    end else if (is_quote) begin
                        // opening quote of a field
                        a_valid = 1'b0;
                        a_phase = PH_QUOTED;
                    end else begin
                        a_res   = make_res(data_byte, KIND_CONTENT, col, row, ERR_NONE);
                        a_phase = PH_UNQUOTED;
                    end
                end
                PH_QUOTED: begin
                    if (is_quote) begin
                        a_phase = PH_QUOTE_SEEN;
                    end else begin
                        a_valid = 1'b1;
                        a_res   = make_res(data_byte, KIND_CONTENT, col, row, ERR_NONE);
                    end
                end
                default: begin
                    a_phase = PH_SKIP;
                end
            endcase
        end
    end

    // line end, from a newline or from the last byte of the stream
    assign e_phase_in = is_nl ? phase : a_phase;
    assign e_col_in   = is_nl ? col : a_col;
    assign do_end     = is_nl || stream_end;
    assign e_count    = EXP_W'(e_col_in) + EXP_W'(1);

    always_comb begin
        e_phase = e_phase_in;
        e_col   = e_col_in;
        e_exp   = exp_cols;
        e_hdr   = hdr_done;
        e_row   = row;
        e_valid = 1'b0;
        e_res   = make_res(8'd0, KIND_ROW_END, e_col_in, row, ERR_NONE);
        if (do_end) begin
            unique case (e_phase_in)
                PH_LINE_START: begin
                    e_valid = 1'b1;
                    e_res   = make_res(8'd0, KIND_ERROR, e_col_in, row, ERR_EMPTY_LINE);
                    e_phase = PH_SKIP;
                end
                PH_QUOTED: begin
                    e_valid = 1'b1;
                    e_res   = make_res(8'd0, KIND_ERROR, e_col_in, row, ERR_UNTERM);
                    e_phase = PH_SKIP;
                end
                PH_FIELD_START, PH_UNQUOTED, PH_QUOTE_SEEN: begin
                    e_valid = 1'b1;
                    if (hdr_done && (e_count != exp_cols)) begin
                        e_res   = make_res(8'd0, KIND_ERROR, e_col_in, row, ERR_COL_COUNT);
                        e_phase = PH_SKIP;
                    end else begin
                        if (!hdr_done) begin
                            e_exp = e_count;
                            e_hdr = 1'b1;
                        end
                        e_row   = (row == ROW_MAX) ? row : row + 24'd1;
                        e_col   = '0;
                        e_phase = PH_LINE_START;
                    end
                end
                default: begin
                    e_phase = PH_SKIP;
                end
            endcase
        end
    end

    // pack results in order and mark the last one
    always_comb begin
        if (a_valid) begin
            res0       = a_res;
            res0_valid = 1'b1;
            res1       = e_res;
            res1_valid = e_valid;
        end else begin
            res0       = e_res;
            res0_valid = e_valid;
            res1       = e_res;
            res1_valid = 1'b0;
        end
        res0.last_of_run = !res1_valid;
        res1.last_of_run = 1'b1;
    end

    // end of stream returns everything to its reset state
    always_comb begin
        if (stream_end) begin
            phase_next    = PH_LINE_START;
            col_next      = '0;
            exp_cols_next = '0;
            hdr_done_next = 1'b0;
            row_next      = '0;
        end else begin
            phase_next    = e_phase;
            col_next      = e_col;
            exp_cols_next = e_exp;
            hdr_done_next = e_hdr;
            row_next      = e_row;
        end
    end

endmodule

// ===== rtl/core/csvp_result_fifo.sv =====
// small result queue taking up to two results per cycle and giving one while rd_ready is high
`timescale 1ns / 1ps

module csvp_result_fifo
    import csvp_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  result_t wr_data0,
    input  logic    wr_en0,
    input  result_t wr_data1,
    input  logic    wr_en1,
    output logic    room_for_two,
    output result_t rd_data,
    output logic    rd_valid,
    input  logic    rd_ready
);

    localparam int PTR_W = $clog2(RES_DEPTH);
    localparam int CNT_W = $clog2(RES_DEPTH + 1);

    result_t          entry_reg [RES_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic [PTR_W-1:0] wr_ptr_plus1;
    logic             pop;
    logic [CNT_W-1:0] push_cnt;

    assign pop          = rd_valid && rd_ready;
    assign push_cnt     = CNT_W'(wr_en0) + CNT_W'(wr_en1);
    assign wr_ptr_plus1 = wr_ptr_reg + PTR_W'(1);
    assign room_for_two = (count_reg <= CNT_W'(RES_DEPTH - 2));
    assign rd_valid     = (count_reg != '0);
    assign rd_data      = entry_reg[rd_ptr_reg];

    // pointer and fill level bookkeeping
    assign wr_ptr_next = wr_ptr_reg + PTR_W'(push_cnt);
    assign rd_ptr_next = rd_ptr_reg + PTR_W'(pop);
    assign count_next  = count_reg + push_cnt - CNT_W'(pop);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // result storage, second result goes one slot after the first
    always_ff @(posedge aclk) begin
        if (wr_en0) begin
            entry_reg[wr_ptr_reg] <= wr_data0;
        end
        if (wr_en1) begin
            entry_reg[wr_ptr_plus1] <= wr_data1;
        end
    end

endmodule
